// File: sv/calendar_date_counter_assert.svh
// ---------------------------------------------------------------------------
// calendar date counter assertion macros
// shared property forms, clocked on clk; the first two are disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef CALENDAR_DATE_COUNTER_ASSERT_SVH
`define CALENDAR_DATE_COUNTER_ASSERT_SVH

// same-cycle implication, off during reset
`define CALDATE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CALDATE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked in reset too
`define CALDATE_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/caldate_pkg.sv
// ---------------------------------------------------------------------------
// caldate_pkg
// types, codes and date arithmetic helpers for the calendar date counter
// ---------------------------------------------------------------------------
`default_nettype none

package caldate_pkg;

  // operation codes carried on in_tuser
  typedef enum logic [1:0] {
    FN_SET  = 2'd0,
    FN_NEXT = 2'd1,
    FN_PREV = 2'd2,
    FN_DIFF = 2'd3
  } func_t;

  // date limits
  localparam logic [11:0] YEAR_MIN   = 12'd1900;
  localparam logic [11:0] YEAR_MAX   = 12'd2100;
  localparam logic [11:0] YEAR_TOP   = 12'd4095;
  localparam logic [11:0] YEAR_RESET = 12'd1900;
  localparam logic [3:0]  MONTH_JAN  = 4'd1;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [3:0]  MONTH_DEC  = 4'd12;
  localparam logic [4:0]  DAY_FIRST  = 5'd1;
  localparam logic [4:0]  DAY_DEC31  = 5'd31;

  // day number of 1/1/1900
  localparam logic [20:0] DN_EPOCH = 21'd693962;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic [20:0] days_between;
    logic [4:0]  month_length;
    logic        leap_year;
    logic        given_valid;
    logic [11:0] cur_year;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
  } res_t;

  localparam int RES_W  = $bits(res_t);
  localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

  // x / 100 by reciprocal, exact for x below 43699
  function automatic logic [6:0] div100(input logic [12:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'd5243;
    return p[25:19];
  endfunction

  // gregorian leap year
  function automatic logic is_leap(input logic [11:0] y);
    logic [6:0]  q;
    logic [11:0] r;
    q = div100({1'b0, y});
    r = y - 12'(q) * 12'd100;
    return ((y[1:0] == 2'b00) && (r != 12'd0)) || ((r == 12'd0) && (q[1:0] == 2'b00));
  endfunction

  // last day of a month
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the months before m, non-leap
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    unique case (m)
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      4'd2:    n = 9'd31;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // day number: 365*y + leap years before y + days before month + day, +1 past feb in a leap year
  function automatic logic [20:0] day_number(input logic [3:0] m, input logic [4:0] d,
                                             input logic [11:0] y);
    logic [12:0] y3;
    logic [12:0] y99;
    logic [12:0] y399;
    logic [6:0]  q400;
    logic [20:0] n;
    y3   = {1'b0, y} + 13'd3;
    y99  = {1'b0, y} + 13'd99;
    y399 = {1'b0, y} + 13'd399;
    q400 = div100(y399) >> 2;
    n = 21'(y) * 21'd365 + 21'(y3[12:2]) - 21'(div100(y99)) + 21'(q400)
        + 21'(days_before(m)) + 21'(d);
    if ((m > MONTH_FEB) && is_leap(y)) begin
      n = n + 21'd1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: sv/calendar_date_counter.sv
// an accepted item's result is registered into the output buffer and shown on out_* from there
// throughput: one item per cycle while in_tready is high, set by the combinational
//   date update of the stored date and its running day number
// a two-word output buffer lets in_tready stay high while one result waits
// reset (rst_n low, synchronous): stored date 1/1/1900, output buffer empty
// ---------------------------------------------------------------------------
// calendar_date_counter
// gregorian date register with set, next/previous day and day difference
// ---------------------------------------------------------------------------
`default_nettype none

module calendar_date_counter
  import caldate_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output      logic               in_tready,
  input  wire logic [23:0]        in_tdata,   // in_month[3:0], in_day[8:4], in_year[20:9]
  input  wire logic [1:0]         in_tuser,   // func[1:0]
  output      logic               out_tvalid,
  input  wire logic               out_tready,
  output      logic [TDATA_W-1:0] out_tdata   // cur_month[3:0], cur_day[8:4],
                                              // cur_year[20:9], given_valid[21],
                                              // leap_year[22], month_length[27:23],
                                              // days_between[48:28]
);

  // stored date and its day number
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [11:0] year_r, year_nxt;
  logic [20:0] dn_r, dn_nxt;

  // output buffer
  res_t out_res_r;
  res_t skid_res_r;
  logic out_vld_r;
  logic skid_vld_r;

  func_t       func;
  logic [3:0]  g_month;
  logic [4:0]  g_day;
  logic [11:0] g_year;
  logic        g_leap;
  logic        g_ok;
  logic [20:0] g_dn;
  logic [20:0] ref_dn;
  logic [20:0] diff;
  logic        leap_cur;
  logic [4:0]  mlen_cur;
  logic        at_top;
  logic        at_bottom;
  logic        valid_nxt;
  logic [20:0] between_nxt;
  logic        leap_nxt;
  res_t        res_nxt;
  logic        accept;
  logic        pop;

  assign func    = func_t'(in_tuser);
  assign g_month = in_tdata[3:0];
  assign g_day   = in_tdata[8:4];
  assign g_year  = in_tdata[20:9];

  assign accept = in_tvalid && in_tready;
  assign pop    = out_vld_r && out_tready;

  // given date check and its day number
  always_comb begin
    g_leap = is_leap(g_year);
    g_ok   = (g_year >= YEAR_MIN) && (g_year <= YEAR_MAX) &&
             (g_month >= MONTH_JAN) && (g_month <= MONTH_DEC) &&
             (g_day >= DAY_FIRST) && (g_day <= month_len(g_month, g_leap));
    g_dn   = day_number(g_month, g_day, g_year);
    ref_dn = g_ok ? g_dn : DN_EPOCH;
    diff   = (dn_r >= ref_dn) ? (dn_r - ref_dn) : (ref_dn - dn_r);
  end

  // stored date update
  always_comb begin
    leap_cur    = is_leap(year_r);
    mlen_cur    = month_len(month_r, leap_cur);
    at_top      = (month_r == MONTH_DEC) && (day_r == DAY_DEC31) && (year_r == YEAR_TOP);
    at_bottom   = (month_r == MONTH_JAN) && (day_r == DAY_FIRST) && (year_r == 12'd0);
    month_nxt   = month_r;
    day_nxt     = day_r;
    year_nxt    = year_r;
    dn_nxt      = dn_r;
    valid_nxt   = 1'b0;
    between_nxt = '0;
    unique case (func)
      FN_SET: begin
        valid_nxt = g_ok;
        if (g_ok) begin
          month_nxt = g_month;
          day_nxt   = g_day;
          year_nxt  = g_year;
          dn_nxt    = g_dn;
        end else begin
          month_nxt = MONTH_JAN;
          day_nxt   = DAY_FIRST;
          year_nxt  = YEAR_RESET;
          dn_nxt    = DN_EPOCH;
        end
      end
      FN_NEXT: begin
        if (!at_top) begin
          dn_nxt = dn_r + 21'd1;
          if (day_r >= mlen_cur) begin
            day_nxt = DAY_FIRST;
            if (month_r >= MONTH_DEC) begin
              month_nxt = MONTH_JAN;
              year_nxt  = year_r + 12'd1;
            end else begin
              month_nxt = month_r + 4'd1;
            end
          end else begin
            day_nxt = day_r + 5'd1;
          end
        end
      end
      FN_PREV: begin
        if (!at_bottom) begin
          dn_nxt = dn_r - 21'd1;
          if (day_r <= DAY_FIRST) begin
            if (month_r <= MONTH_JAN) begin
              // new year eve of the year before
              month_nxt = MONTH_DEC;
              year_nxt  = year_r - 12'd1;
              day_nxt   = DAY_DEC31;
            end else begin
              month_nxt = month_r - 4'd1;
              day_nxt   = month_len(month_r - 4'd1, leap_cur);
            end
          end else begin
            day_nxt = day_r - 5'd1;
          end
        end
      end
      FN_DIFF: begin
        valid_nxt   = g_ok;
        between_nxt = diff;
      end
    endcase
  end

  // result word
  always_comb begin
    leap_nxt             = is_leap(year_nxt);
    res_nxt.cur_month    = month_nxt;
    res_nxt.cur_day      = day_nxt;
    res_nxt.cur_year     = year_nxt;
    res_nxt.given_valid  = valid_nxt;
    res_nxt.leap_year    = leap_nxt;
    res_nxt.month_length = month_len(month_nxt, leap_nxt);
    res_nxt.days_between = between_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      month_r <= MONTH_JAN;
      day_r   <= DAY_FIRST;
      year_r  <= YEAR_RESET;
      dn_r    <= DN_EPOCH;
    end else if (accept) begin
      month_r <= month_nxt;
      day_r   <= day_nxt;
      year_r  <= year_nxt;
      dn_r    <= dn_nxt;
    end
  end

  // output buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (accept) begin
      if (out_vld_r && !pop) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (pop) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // output buffer payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (out_vld_r && !pop) begin
        skid_res_r <= res_nxt;
      end else begin
        out_res_r <= res_nxt;
      end
    end else if (pop && skid_vld_r) begin
      out_res_r <= skid_res_r;
    end
  end

  assign in_tready  = !skid_vld_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(TDATA_W - RES_W)'(0), out_res_r};

endmodule

`default_nettype wire

// File: sv/caldate_chk.sv
// ---------------------------------------------------------------------------
// caldate_chk
// port-level checks for the calendar date counter, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "calendar_date_counter_assert.svh"

module caldate_chk
  import caldate_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tvalid,
  input wire logic               in_tready,
  input wire logic [23:0]        in_tdata,   // in_month[3:0], in_day[8:4], in_year[20:9]
  input wire logic [1:0]         in_tuser,   // func[1:0]
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [TDATA_W-1:0] out_tdata   // result word, see top level
);

  res_t res;
  logic in_seen;

  assign res     = res_t'(out_tdata[RES_W-1:0]);
  assign in_seen = in_tvalid || in_tready || (in_tdata != '0) || (in_tuser != '0);

  // a stalled result holds
  `CALDATE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "stalled result changed")

  // a valid result's day always lies within its month
  `CALDATE_ASSERT_NOW(a_day_in_month, out_tvalid,
    (res.cur_day != 5'd0) && (res.cur_day <= res.month_length),
    "stored day outside month length")

  // a 29-day month only for february of a leap year
  `CALDATE_ASSERT_NOW(a_leap_feb, out_tvalid && (res.month_length == 5'd29),
    res.leap_year && (res.cur_month == MONTH_FEB), "bad leap february")

  // reset empties the output buffer
  `CALDATE_ASSERT_ALWAYS(a_reset_empty, !rst_n || !in_seen && !rst_n,
    !out_tvalid, "result valid after reset")

endmodule

bind calendar_date_counter caldate_chk u_caldate_chk (.*);

`default_nettype wire
